// File: rtl/core/sdw_pkg.sv
package sdw_pkg;

  // Walk phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TABLE = 2'd1;
  localparam logic [1:0] PH_NEXT  = 2'd2;
  localparam logic [1:0] PH_SIZE  = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_TABLE  = 3'd0;
  localparam logic [2:0] KIND_NEXT   = 3'd1;
  localparam logic [2:0] KIND_SIZE   = 3'd2;
  localparam logic [2:0] KIND_SUBMIT = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] REG_TABLE_BASE  = 8'd0;
  localparam logic [7:0] REG_LINK_BASE   = 8'd1;
  localparam logic [7:0] REG_TABLE_WIDE  = 8'd2;
  localparam logic [7:0] REG_LINK_SCALED = 8'd3;

  // Input operations
  localparam logic OP_RESPONSE = 1'b0;
  localparam logic OP_START    = 1'b1;

  // Link entry layout and chain markers
  localparam logic [23:0] NEXT_OFS   = 24'h00001C;
  localparam logic [23:0] SIZE_OFS   = 24'h000018;
  localparam logic [31:0] ALIGN_MASK = ~32'd31;
  localparam logic [31:0] BATCH_STEP = 32'd32;
  localparam logic [31:0] END_LINK   = 32'd2;
  localparam logic [31:0] MORE_LINK  = 32'd1;

  // Result queue depth
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [31:0] table_base;
    logic [31:0] chain_base;
    logic        table_wide;
    logic        link_scaled;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] address;
    logic        wide_read;
    logic [31:0] list_size;
    logic        last;
  } result_t;

endpackage

// File: rtl/core/sdw_walker.sv
module sdw_walker #(
  parameter int RAM_ADDR_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  sdw_pkg::cfg_t    cfg,
  input  logic             batch_clear,
  input  logic             go,
  input  logic             op,
  input  logic [31:0]      word,
  output sdw_pkg::result_t res0,
  output logic             res0_valid,
  output sdw_pkg::result_t res1,
  output logic             res1_valid
);

  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << RAM_ADDR_BITS) - 64'd1);

  logic [1:0]  phase, phase_next;
  logic [31:0] table_index, table_index_next;
  logic [31:0] batch_offset, batch_offset_next;
  logic [23:0] entry_address, entry_address_next;
  logic [31:0] pending_link, pending_link_next;

  logic [31:0]      idx_base, tbl_ofs, tbl_addr;
  logic [31:0]      link_sel, link_ofs, ent_full, nxt_full;
  logic             link_end;
  sdw_pkg::result_t table_res, follow_res, size_res, submit_res;

  // Table entry address for the current index (index 0 on a start).
  always_comb begin
    idx_base = (op == sdw_pkg::OP_START) ? 32'd0 : table_index;
    tbl_ofs  = cfg.table_wide ? {idx_base[29:0], 2'b00} : {idx_base[30:0], 1'b0};
    tbl_addr = (cfg.table_base + batch_offset + tbl_ofs) & ADDR_MASK;
    table_res = '{kind: sdw_pkg::KIND_TABLE, address: tbl_addr[23:0],
                  wide_read: cfg.table_wide, list_size: 32'd0, last: 1'b1};
  end

  // Link following: from a table entry, or from the pending next link.
  always_comb begin
    if (phase == sdw_pkg::PH_SIZE) begin
      link_sel = pending_link;
    end else begin
      link_sel = cfg.table_wide ? word : {16'd0, word[15:0]};
    end
    link_ofs = cfg.link_scaled ? {link_sel[26:0], 5'd0} : (link_sel & sdw_pkg::ALIGN_MASK);
    ent_full = (cfg.chain_base + link_ofs) & ADDR_MASK;
    nxt_full = (cfg.chain_base + link_ofs + {8'd0, sdw_pkg::NEXT_OFS}) & ADDR_MASK;
    link_end = (link_sel == sdw_pkg::END_LINK);
    if (link_end) begin
      follow_res = '{kind: sdw_pkg::KIND_DONE, address: 24'd0, wide_read: 1'b0,
                     list_size: 32'd0, last: 1'b1};
    end else begin
      follow_res = '{kind: sdw_pkg::KIND_NEXT, address: nxt_full[23:0], wide_read: 1'b1,
                     list_size: 32'd0, last: 1'b1};
    end
  end

  // Size read and list submit for the current entry.
  always_comb begin
    size_res   = '{kind: sdw_pkg::KIND_SIZE,
                   address: (entry_address + sdw_pkg::SIZE_OFS) & ADDR_MASK[23:0],
                   wide_read: 1'b1, list_size: 32'd0, last: 1'b1};
    submit_res = '{kind: sdw_pkg::KIND_SUBMIT, address: entry_address, wide_read: 1'b0,
                   list_size: word, last: 1'b0};
  end

  // One walk step per processed item.
  always_comb begin
    phase_next         = phase;
    table_index_next   = table_index;
    batch_offset_next  = batch_offset;
    entry_address_next = entry_address;
    pending_link_next  = pending_link;
    res0               = '0;
    res1               = '0;
    res0_valid         = 1'b0;
    res1_valid         = 1'b0;
    if (go) begin
      if (op == sdw_pkg::OP_START) begin
        res0             = table_res;
        res0_valid       = 1'b1;
        table_index_next = idx_base + 32'd1;
        phase_next       = sdw_pkg::PH_TABLE;
      end else begin
        case (phase)
          sdw_pkg::PH_TABLE: begin
            res0       = follow_res;
            res0_valid = 1'b1;
            if (link_end) begin
              batch_offset_next = batch_offset + sdw_pkg::BATCH_STEP;
              phase_next        = sdw_pkg::PH_IDLE;
            end else begin
              entry_address_next = ent_full[23:0];
              phase_next         = sdw_pkg::PH_NEXT;
            end
          end
          sdw_pkg::PH_NEXT: begin
            res0              = size_res;
            res0_valid        = 1'b1;
            pending_link_next = word;
            phase_next        = sdw_pkg::PH_SIZE;
          end
          sdw_pkg::PH_SIZE: begin
            res0       = submit_res;
            res0_valid = 1'b1;
            res1_valid = 1'b1;
            if (pending_link == sdw_pkg::MORE_LINK) begin
              res1             = table_res;
              table_index_next = idx_base + 32'd1;
              phase_next       = sdw_pkg::PH_TABLE;
            end else begin
              res1 = follow_res;
              if (link_end) begin
                batch_offset_next = batch_offset + sdw_pkg::BATCH_STEP;
                phase_next        = sdw_pkg::PH_IDLE;
              end else begin
                entry_address_next = ent_full[23:0];
                phase_next         = sdw_pkg::PH_NEXT;
              end
            end
          end
          default: begin
            // A response with no walk in progress is dropped.
          end
        endcase
      end
    end
    if (batch_clear) begin
      batch_offset_next = 32'd0;
    end
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdw_pkg::PH_IDLE;
      table_index   <= 32'd0;
      batch_offset  <= 32'd0;
      entry_address <= 24'd0;
      pending_link  <= 32'd0;
    end else begin
      phase         <= phase_next;
      table_index   <= table_index_next;
      batch_offset  <= batch_offset_next;
      entry_address <= entry_address_next;
      pending_link  <= pending_link_next;
    end
  end

  // A done result always leaves the walker idle.
  assert property (@(posedge clk) disable iff (rst)
    (go && ((res0_valid && res0.kind == sdw_pkg::KIND_DONE) ||
            (res1_valid && res1.kind == sdw_pkg::KIND_DONE)))
    |=> (phase == sdw_pkg::PH_IDLE))
    else $error("walker not idle after done");

  // Two results come only from the size phase.
  assert property (@(posedge clk) disable iff (rst)
    res1_valid |-> (res0_valid && phase == sdw_pkg::PH_SIZE && op == sdw_pkg::OP_RESPONSE))
    else $error("second result outside size phase");

  // A start always moves the walker to the table phase.
  assert property (@(posedge clk) disable iff (rst)
    (go && op == sdw_pkg::OP_START) |=> (phase == sdw_pkg::PH_TABLE))
    else $error("walker not in table phase after start");

endmodule

// File: rtl/core/sdw_result_queue.sv
module sdw_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  sdw_pkg::result_t push0_data,
  input  logic             push0,
  input  sdw_pkg::result_t push1_data,
  input  logic             push1,
  output logic             room,
  output sdw_pkg::result_t head,
  output logic             head_valid,
  input  logic             pop
);

  localparam int PTR_W = $clog2(sdw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  sdw_pkg::result_t entries [sdw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] wr_ptr1;
  logic             do_pop;

  always_comb begin
    do_pop     = pop && (count != '0);
    wr_ptr1    = wr_ptr + PTR_W'(1);
    count_next = count + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(do_pop);
    head       = entries[rd_ptr];
    head_valid = (count != '0);
    room       = (count <= CNT_W'(sdw_pkg::QUEUE_DEPTH - 2));
  end

  // Storage: up to two writes per cycle at consecutive slots.
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= push0_data;
    end
    if (push1) begin
      entries[wr_ptr1] <= push1_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push0) + PTR_W'(push1);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(sdw_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    push1 |-> (push0 && room))
    else $error("second push without first or without room");

  assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (count == '0 && !head_valid))
    else $error("result queue not empty after reset");

endmodule

// File: rtl/core/sort_dma_link_list_walker_unit.sv
// Sort-DMA link-list walker. A start command (s_tuser = 1) issues the first
// start-link table read; each read response (s_tuser = 0) on s_tdata moves the
// walk one step and yields the next request on the master side: table read,
// next-link read, size read, list submit, or done. The response to a size read
// yields two transfers (submit, then the next request), all others one; a
// response with no walk in progress yields none. One input transfer can be
// taken every cycle while processing does not stall: it lands in an input
// register, is processed once the queue has room and is written to a
// four-entry result queue, from whose head a result is offered on the master
// side. The queue drains one result per cycle while m_tready is high, and
// processing stalls only while it has room for fewer than two results.
// Configuration writes are accepted every cycle and should be made with no
// walk in progress; writing table_base clears the batch offset.
module sort_dma_link_list_walker_unit #(
  parameter int RAM_ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] read_word
  input  logic        s_tuser,   // [0] operation
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [23:0] address, [24] wide_read, [56:25] list_size
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sdw_pkg::cfg_t    cfg;
  logic             in_full;
  logic             in_op;
  logic [31:0]      in_word;
  logic             go;
  logic             room;
  logic             cfg_write;
  sdw_pkg::result_t res0, res1, head;
  logic             res0_valid, res1_valid;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign go        = in_full && room;
  assign s_tready  = !in_full || go;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sdw_pkg::REG_TABLE_BASE:  cfg.table_base  <= cfg_data;
        sdw_pkg::REG_LINK_BASE:   cfg.chain_base  <= cfg_data;
        sdw_pkg::REG_TABLE_WIDE:  cfg.table_wide  <= cfg_data[0];
        sdw_pkg::REG_LINK_SCALED: cfg.link_scaled <= cfg_data[0];
        default: begin
          // Writes to unknown indexes are ignored.
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_word <= s_tdata;
    end
  end

  sdw_walker #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .batch_clear(cfg_write && cfg_index == sdw_pkg::REG_TABLE_BASE),
    .go         (go),
    .op         (in_op),
    .word       (in_word),
    .res0       (res0),
    .res0_valid (res0_valid),
    .res1       (res1),
    .res1_valid (res1_valid)
  );

  sdw_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0_data(res0),
    .push0     (res0_valid),
    .push1_data(res1),
    .push1     (res1_valid),
    .room      (room),
    .head      (head),
    .head_valid(m_tvalid),
    .pop       (m_tready)
  );

  // Result packing.
  assign m_tdata = {7'd0, head.list_size, head.wide_read, head.address};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule
